>>> hw/rtl/gtp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the glyph to planar tile packer.
// Used by gtp_width_tracker and glyph_to_planar_tile_packer; no dependencies.
package gtp_pkg;

  // Glyph geometry
  localparam int unsigned GlyphSide = 12;
  localparam logic [3:0]  LastIdx   = 4'(GlyphSide - 1);
  localparam logic [3:0]  MaxWidth  = 4'(GlyphSide);
  localparam logic [7:0]  StopPixel = 8'd5;
  localparam logic [3:0]  CondenseLimit = 4'd10;
  localparam int unsigned NumFaces  = 2;

  // Configuration register indexes
  localparam logic [2:0] CfgFace0Begin    = 3'd0;
  localparam logic [2:0] CfgFace0End      = 3'd1;
  localparam logic [2:0] CfgFace0Condense = 3'd2;
  localparam logic [2:0] CfgFace1Begin    = 3'd3;
  localparam logic [2:0] CfgFace1End      = 3'd4;
  localparam logic [2:0] CfgFace1Condense = 3'd5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  // One condensed character range
  typedef struct packed {
    logic [9:0]  begin_code;
    logic [10:0] end_code;
    logic [3:0]  condense;
  } gtp_face_t;

  typedef gtp_face_t [NumFaces-1:0] gtp_face_cfg_t;

  // Input request payload
  typedef struct packed {
    logic [7:0] pixel;
    logic [9:0] source_code;
    logic [9:0] tile_index;
  } gtp_in_t;

  // Result payload
  typedef struct packed {
    logic [3:0]  row;
    logic [14:0] wide_address;
    logic [7:0]  wide_plane0;
    logic [7:0]  wide_plane1;
    logic [13:0] narrow_address;
    logic [7:0]  narrow_plane0;
    logic [7:0]  narrow_plane1;
    logic        narrow_high;
    logic [3:0]  glyph_width;
    logic        last_row;
  } gtp_out_t;

  // Per-pixel control toward the width tracker
  typedef struct packed {
    logic take;      // pixel accepted this cycle
    logic first;     // pixel zero of a glyph
    logic row_zero;  // pixel lies in row zero
    logic row_end;   // last pixel of a row
  } gtp_width_ctrl_t;

  // Map a raw pixel to its 2-bit plane value (bit 0, bit 1)
  function automatic logic [1:0] map_pixel(input logic [7:0] raw);
    logic [1:0] v;
    unique case (raw)
      8'd0:    v = 2'd0;
      8'd1:    v = 2'd0;
      8'd2:    v = 2'd1;
      8'd3:    v = 2'd2;
      8'd4:    v = 2'd3;
      8'd5:    v = 2'd0;
      default: v = raw[1:0];
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/glyph_to_planar_tile_packer.sv
`timescale 1ns / 1ps
// Top level of the glyph to planar tile packer.
// Depends on gtp_pkg and gtp_width_tracker.
//
// Accepts one raw pixel of a 12x12 glyph per clock, row-major, and after the
// twelfth pixel of each row presents one result in a single output register:
// the two 2bpp wide-table bytes for pixels 0-7, the two nibbles for pixels
// 8-11 and their byte addresses. The result register loads as the last pixel
// of a row is accepted; the block sustains one pixel per cycle unless stalled.
// The only source of input stall is a full result register whose request is
// stalled downstream; source code and tile are latched at pixel zero.
// Configuration writes take effect at once and must be made between glyphs.
module glyph_to_planar_tile_packer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [gtp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [gtp_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // pixel requests
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  gtp_pkg::gtp_in_t               in_data_i,
  // row results
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output gtp_pkg::gtp_out_t              out_data_o
);
  import gtp_pkg::*;

  gtp_face_cfg_t   face_cfg_q;
  logic [3:0]      row_q, row_d;
  logic [3:0]      col_q, col_d;
  logic [11:0]     plane0_q, plane0_d;
  logic [11:0]     plane1_q, plane1_d;
  logic [9:0]      held_source_q, held_source_d;
  logic [9:0]      held_tile_q, held_tile_d;
  logic            out_valid_q, out_valid_d;
  gtp_out_t        out_data_q, out_data_d;
  logic            accept;
  logic            first_pixel;
  logic            row_end;
  logic [1:0]      mapped;
  logic [3:0]      width;
  logic            tile_even;
  logic [8:0]      half_tile;
  gtp_width_ctrl_t width_ctrl;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFace0Begin:    face_cfg_q[0].begin_code <= cfg_wdata_i[9:0];
        CfgFace0End:      face_cfg_q[0].end_code   <= cfg_wdata_i;
        CfgFace0Condense: face_cfg_q[0].condense   <= cfg_wdata_i[3:0];
        CfgFace1Begin:    face_cfg_q[1].begin_code <= cfg_wdata_i[9:0];
        CfgFace1End:      face_cfg_q[1].end_code   <= cfg_wdata_i;
        CfgFace1Condense: face_cfg_q[1].condense   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Hold input while a finished result waits downstream
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign first_pixel = (row_q == 4'd0) && (col_q == 4'd0);
  assign row_end     = (col_q == LastIdx);

  // Advance position, latch glyph identity, shift bitplanes
  always_comb begin
    mapped        = map_pixel(in_data_i.pixel);
    col_d         = row_end ? 4'd0 : col_q + 4'd1;
    row_d         = row_end ? ((row_q == LastIdx) ? 4'd0 : row_q + 4'd1) : row_q;
    held_source_d = first_pixel ? in_data_i.source_code : held_source_q;
    held_tile_d   = first_pixel ? in_data_i.tile_index : held_tile_q;
    plane0_d      = {plane0_q[10:0], mapped[0]};
    plane1_d      = {plane1_q[10:0], mapped[1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q         <= 4'd0;
      col_q         <= 4'd0;
      plane0_q      <= '0;
      plane1_q      <= '0;
      held_source_q <= '0;
      held_tile_q   <= '0;
    end else if (accept) begin
      row_q         <= row_d;
      col_q         <= col_d;
      plane0_q      <= plane0_d;
      plane1_q      <= plane1_d;
      held_source_q <= held_source_d;
      held_tile_q   <= held_tile_d;
    end
  end

  // Width measurement
  assign width_ctrl = '{
    take:     accept,
    first:    first_pixel,
    row_zero: (row_q == 4'd0),
    row_end:  row_end
  };

  gtp_width_tracker u_width (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (width_ctrl),
    .pixel_i       (in_data_i.pixel),
    .held_source_i (held_source_q),
    .face_cfg_i    (face_cfg_q),
    .width_o       (width)
  );

  // Build the row result; tile*24 is tile*16 + tile*8
  always_comb begin
    tile_even = ~held_tile_q[0];
    half_tile = held_tile_q[9:1];
    out_data_d.row            = row_q;
    out_data_d.wide_address   = ({1'b0, held_tile_q, 4'd0} + {2'b0, held_tile_q, 3'd0})
                              + {10'd0, row_q, 1'b0};
    out_data_d.wide_plane0    = plane0_d[11:4];
    out_data_d.wide_plane1    = plane1_d[11:4];
    out_data_d.narrow_address = ({1'b0, half_tile, 4'd0} + {2'b0, half_tile, 3'd0})
                              + {9'd0, row_q, 1'b0};
    out_data_d.narrow_plane0  = tile_even ? {plane0_d[3:0], 4'd0} : {4'd0, plane0_d[3:0]};
    out_data_d.narrow_plane1  = tile_even ? {plane1_d[3:0], 4'd0} : {4'd0, plane1_d[3:0]};
    out_data_d.narrow_high    = tile_even;
    out_data_d.glyph_width    = width;
    out_data_d.last_row       = (row_q == LastIdx);
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d = accept && row_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && row_end) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= LastIdx && col_q <= LastIdx)
    else $error("glyph position out of range");

  a_row_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && row_end |=> out_valid_q && out_data_q.row == $past(row_q))
    else $error("row end did not produce a result");

  a_glyph_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && row_end && row_q == LastIdx |=> row_q == 4'd0 && col_q == 4'd0)
    else $error("glyph did not wrap after last pixel");

  a_width_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q.glyph_width <= MaxWidth)
    else $error("glyph width above cap");

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_data_q))
    else $error("stalled result dropped or changed");

endmodule

>>> hw/rtl/gtp_width_tracker.sv
`timescale 1ns / 1ps
// Glyph width measurement and range condensing for the tile packer.
// Depends on gtp_pkg.
module gtp_width_tracker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gtp_pkg::gtp_width_ctrl_t ctrl_i,
  input  logic [7:0]              pixel_i,
  input  logic [9:0]              held_source_i,
  input  gtp_pkg::gtp_face_cfg_t  face_cfg_i,
  output logic [3:0]              width_o
);
  import gtp_pkg::*;

  logic [3:0] count_q, count_d;
  logic       stopped_q, stopped_d;
  logic [3:0] count_base, count_run, count_cond;
  logic       stopped_base, stopped_run;

  // Count leading non-stop pixels of row zero
  always_comb begin
    count_base   = ctrl_i.first ? 4'd0 : count_q;
    stopped_base = ctrl_i.first ? 1'b0 : stopped_q;
    count_run    = count_base;
    stopped_run  = stopped_base;
    if (ctrl_i.row_zero && !stopped_base) begin
      if (pixel_i != StopPixel && count_base < MaxWidth) begin
        count_run = count_base + 4'd1;
      end else begin
        stopped_run = 1'b1;
      end
    end
  end

  // Apply range zero, then range one
  always_comb begin
    count_cond = count_run;
    for (int k = 0; k < NumFaces; k++) begin
      if ({1'b0, held_source_i} >= {1'b0, face_cfg_i[k].begin_code} &&
          {1'b0, held_source_i} < face_cfg_i[k].end_code &&
          face_cfg_i[k].condense != 4'd0 &&
          face_cfg_i[k].condense < CondenseLimit &&
          count_cond >= face_cfg_i[k].condense) begin
        count_cond = count_cond - face_cfg_i[k].condense;
      end
    end
  end

  // Settle the width at the end of row zero
  always_comb begin
    count_d   = (ctrl_i.row_zero && ctrl_i.row_end) ? count_cond : count_run;
    stopped_d = stopped_run;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= 4'd0;
      stopped_q <= 1'b0;
    end else if (ctrl_i.take) begin
      count_q   <= count_d;
      stopped_q <= stopped_d;
    end
  end

  assign width_o = count_d;

endmodule
